/* src/rbb_pkg.sv */
// Shared types and constants for the RGB box blur block.
`default_nettype none
package rbb_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd2;

  localparam int CFG_DATA_W   = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int H_W          = 13;  // holds a row count up to HEIGHT_LIMIT
  localparam int M_W          = 4;   // window side, as wide as its register
  localparam int AREA_W       = 8;   // m*m for m up to 15
  localparam int SUM_W        = 16;  // 225 * 255 fits
  localparam int DIV_CNT_W    = 4;   // SUM_W quotient bits, one per step

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INIT,
    ST_SCAN,
    ST_CENTRE,
    ST_ALPHA,
    ST_DIVIDE,
    ST_LOAD
  } rbb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic init;
    logic scan;
    logic centre;
    logic alpha;
    logic div_step;
    logic load;
    logic emit;
  } rbb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic check_next;
    logic emit_due;
    logic scan_last;
    logic div_last;
    logic out_free;
  } rbb_stat_t;

endpackage
`default_nettype wire

/* src/rbb_if.sv */
// Pixel input and output channel interfaces.
`default_nettype none
interface rbb_pix_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, action, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rbb_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       frame_last;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_last,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_last,
                  output ready);
endinterface
`default_nettype wire

/* src/rbb_ctrl.sv */
// Controller state machine that sequences one item at a time.
`default_nettype none
module rbb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  rbb_pkg::rbb_stat_t  stat,
  output rbb_pkg::rbb_cmd_t   cmd
);
  import rbb_pkg::*;

  rbb_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (stat.check_next) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stat.emit_due ? ST_INIT : ST_IDLE;
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_next = ST_CENTRE;
      end
      ST_CENTRE: begin
        cmd.centre = 1'b1;
        state_next = ST_ALPHA;
      end
      ST_ALPHA: begin
        cmd.alpha  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // The result register fills once the previous beat has gone out.
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* src/rbb_datapath.sv */
// Datapath: registers, line store, window accumulators, dividers, result register.
`default_nettype none
module rbb_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
  rbb_pix_in_if.sink                         pix_in,
  rbb_pix_out_if.source                      pix_out,
  input  rbb_pkg::rbb_cmd_t                  cmd,
  output rbb_pkg::rbb_stat_t                 stat
);
  import rbb_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int CIW   = $clog2(MAX_WIDTH);
  localparam int CPW   = CW + 2;
  localparam int RPW   = H_W + 1;
  localparam int SW    = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = (MAX_WINDOW + 1) * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(HEIGHT_LIMIT * MAX_WIDTH + 1);

  // Configuration registers.
  logic [10:0]    image_width;
  logic [H_W-1:0] image_height;
  logic [M_W-1:0] window_size;
  logic           restart;

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_WINDOW_SIZE: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
      window_size  <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[H_W-1:0];
        CFG_WINDOW_SIZE:  window_size  <= cfg_data[M_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame geometry.
  logic [CW-1:0]  w_eff;
  logic [H_W-1:0] h_eff;
  logic [M_W-1:0] m_eff;
  logic [M_W-1:0] back;
  logic [M_W-1:0] fwd;

  always_comb begin
    if (image_width == 11'd0) w_eff = CW'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    if (image_height == '0) h_eff = H_W'(1);
    else if (32'(image_height) > HEIGHT_LIMIT) h_eff = H_W'(HEIGHT_LIMIT);
    else h_eff = image_height;
    if (window_size == '0) m_eff = M_W'(1);
    else if (32'(window_size) > MAX_WINDOW) m_eff = M_W'(MAX_WINDOW);
    else m_eff = window_size;
    back = m_eff >> 1;
    fwd  = m_eff - M_W'(1) - back;
  end

  // Lag in pixels and window area, registered from the configuration.
  logic [DW-1:0]     lag;
  logic [AREA_W-1:0] area;
  logic [CW-1:0]     fwd_cap;

  always_comb begin
    if (CW'(fwd) < w_eff - CW'(1)) fwd_cap = CW'(fwd);
    else fwd_cap = w_eff - CW'(1);
  end

  always_ff @(posedge clk) begin
    lag  <= DW'(DW'(fwd) * DW'(w_eff)) + DW'(fwd_cap);
    area <= AREA_W'(AREA_W'(m_eff) * AREA_W'(m_eff));
  end

  // Frame position counters.
  logic [H_W-1:0] in_row, out_row;
  logic [CW-1:0]  in_column, out_column;
  logic [SW-1:0]  in_slot, out_slot;
  logic           in_done;
  logic [DW-1:0]  pending;
  logic           accept, store_pix, out_last;

  assign pix_in.ready = cmd.take;
  assign accept       = pix_in.valid && cmd.take;
  assign store_pix    = accept && !in_done && !pix_in.action;
  assign out_last     = (out_row == h_eff - H_W'(1)) && (out_column == w_eff - CW'(1));

  always_ff @(posedge clk) begin
    if (rst || restart || (cmd.load && out_last)) begin
      in_row     <= '0;
      in_column  <= '0;
      in_slot    <= '0;
      in_done    <= 1'b0;
      out_row    <= '0;
      out_column <= '0;
      out_slot   <= '0;
      pending    <= '0;
    end else begin
      if (store_pix) begin
        pending <= pending + DW'(1);
        if (in_column == w_eff - CW'(1)) begin
          in_column <= '0;
          in_row    <= in_row + H_W'(1);
          in_slot   <= (in_slot == SW'(m_eff)) ? '0 : in_slot + SW'(1);
          if (in_row == h_eff - H_W'(1)) in_done <= 1'b1;
        end else begin
          in_column <= in_column + CW'(1);
        end
      end
      if (cmd.load) begin
        pending <= pending - DW'(1);
        if (out_column == w_eff - CW'(1)) begin
          out_column <= '0;
          out_row    <= out_row + H_W'(1);
          out_slot   <= (out_slot == SW'(m_eff)) ? '0 : out_slot + SW'(1);
        end else begin
          out_column <= out_column + CW'(1);
        end
      end
    end
  end

  // Window walk over the line store.
  logic signed [RPW-1:0] row_pos;
  logic signed [CPW-1:0] col_pos, col_start;
  logic [SW-1:0]         win_slot;
  logic [M_W-1:0]        win_i, win_j;
  logic                  in_bounds;

  assign in_bounds = (row_pos >= 0) && (row_pos < $signed({1'b0, h_eff})) &&
                     (col_pos >= 0) && (col_pos < $signed({2'b00, w_eff}));

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      row_pos   <= $signed({1'b0, out_row}) - $signed(RPW'(back));
      col_start <= $signed({2'b00, out_column}) - $signed(CPW'(back));
      col_pos   <= $signed({2'b00, out_column}) - $signed(CPW'(back));
      win_slot  <= (out_slot >= SW'(back)) ? out_slot - SW'(back)
                                           : out_slot + SW'(m_eff) + SW'(1) - SW'(back);
      win_i     <= '0;
      win_j     <= '0;
    end else if (cmd.scan) begin
      if (win_j == m_eff - M_W'(1)) begin
        win_j    <= '0;
        win_i    <= win_i + M_W'(1);
        col_pos  <= col_start;
        row_pos  <= row_pos + RPW'(1);
        win_slot <= (win_slot == SW'(m_eff)) ? '0 : win_slot + SW'(1);
      end else begin
        win_j   <= win_j + M_W'(1);
        col_pos <= col_pos + CPW'(1);
      end
    end
  end

  // Line store: one write port at the input, one registered read port.
  logic [31:0]   line_store [DEPTH];
  logic [31:0]   rd_data;
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_addr = AW'(AW'(in_slot) * AW'(MAX_WIDTH)) + AW'(in_column[CIW-1:0]);

  always_comb begin
    if (cmd.centre) begin
      rd_addr = AW'(AW'(out_slot) * AW'(MAX_WIDTH)) + AW'(out_column[CIW-1:0]);
    end else begin
      rd_addr = AW'(AW'(win_slot) * AW'(MAX_WIDTH)) + AW'(col_pos[CIW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (store_pix) begin
      line_store[wr_addr] <= {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in,
                              pix_in.red_in};
    end
    rd_data <= line_store[rd_addr];
  end

  // Channel sums; a read adds in the cycle after it was issued.
  logic             acc_en;
  logic [SUM_W-1:0] sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.scan && in_bounds;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int c = 0; c < 3; c++) sum[c] <= '0;
    end else if (acc_en) begin
      for (int c = 0; c < 3; c++) sum[c] <= sum[c] + SUM_W'(rd_data[8*c +: 8]);
    end
  end

  // Restoring dividers, one quotient bit per step for each channel.
  logic [SUM_W-1:0]     quo [3];
  logic [AREA_W-1:0]    rem [3];
  logic [AREA_W:0]      trial [3];
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [7:0]           alpha_hold;

  always_comb begin
    for (int c = 0; c < 3; c++) trial[c] = {rem[c], quo[c][SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.alpha) begin
      alpha_hold <= rd_data[31:24];
      div_cnt    <= '0;
      for (int c = 0; c < 3; c++) begin
        quo[c] <= sum[c];
        rem[c] <= '0;
      end
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      for (int c = 0; c < 3; c++) begin
        if (trial[c] >= {1'b0, area}) begin
          rem[c] <= AREA_W'(trial[c] - {1'b0, area});
          quo[c] <= {quo[c][SUM_W-2:0], 1'b1};
        end else begin
          rem[c] <= trial[c][AREA_W-1:0];
          quo[c] <= {quo[c][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // Result register, held until the beat is taken.
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_out.red_out    <= quo[0][7:0];
      pix_out.green_out  <= quo[1][7:0];
      pix_out.blue_out   <= quo[2][7:0];
      pix_out.alpha_out  <= alpha_hold;
      pix_out.frame_last <= out_last;
    end
  end

  assign pix_out.valid = out_valid;

  // Status to the controller. The result register is free when empty or
  // when its beat leaves at this edge; the controller holds its load until then.
  always_comb begin
    stat.check_next = accept && (in_done || !pix_in.action);
    stat.emit_due   = in_done || (pending > lag);
    stat.scan_last  = (win_i == m_eff - M_W'(1)) && (win_j == m_eff - M_W'(1));
    stat.div_last   = (div_cnt == {DIV_CNT_W{1'b1}});
    stat.out_free   = !out_valid || pix_out.ready;
  end

  // No window work while an item is being taken.
  a_no_work_on_take: assert property (@(posedge clk) disable iff (rst)
    accept |-> !cmd.scan && !cmd.load && !cmd.div_step)
    else $error("window work overlaps an accepted item");

  // A finished frame input leaves the input position at the frame end.
  a_done_position: assert property (@(posedge clk) disable iff (rst)
    in_done |-> (in_column == '0) && (in_row == h_eff))
    else $error("input position inconsistent with frame end");

  // A result is only produced for a pixel that has arrived.
  a_pending_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> pending != '0)
    else $error("result loaded with no pixel pending");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !out_valid || pix_out.ready)
    else $error("result register overwritten before its beat left");

endmodule
`default_nettype wire

/* src/rgb_box_blur_top.sv */
// RGB box blur: top level tying controller and datapath together.
//
// Usage: pixels enter on pix_in in raster order, one beat per pixel with
// action low; after the last pixel of a frame, beats with action high
// (flush ticks) drain the results still owed. Blurred pixels leave on
// pix_out, frame_last marks the last one of the frame. Beats follow
// valid/ready: a beat moves at a clock edge where both are high.
// image_width, image_height and window_size are written through the cfg
// port while the block is idle; each write restarts the frame.
// Each beat is handled one at a time. A flush tick before the frame is
// complete leaves the controller idle, any other beat that yields no
// result passes only the check state; one that yields a result goes on
// to the m*m window reads, which go through the single read port of the
// line store one per cycle, and to the three 16-step restoring dividers.
// The result sits in an output register until taken; while a stalled
// receiver keeps it there, the next result waits, with pix_in.ready low,
// until the beat leaves.
// Reset restores width 1024, height 1024, window 3 and starts a new frame;
// the line store needs no clearing, since every entry is written before it
// is read within a frame.
`default_nettype none
module rgb_box_blur_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
  rbb_pix_in_if.sink                          pix_in,
  rbb_pix_out_if.source                       pix_out
);
  import rbb_pkg::*;

  rbb_cmd_t  cmd;
  rbb_stat_t stat;

  // Sequencer.
  rbb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Storage and arithmetic.
  rbb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

/* dv/rbb_checker.sv */
// Passive checker for the RGB box blur: predicts blurred pixels and compares them.
`default_nettype none
module rbb_checker
  import rbb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rbb_pix_in_if                      pix_in,
  rbb_pix_out_if                     pix_out,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = (MAX_WINDOW + 1) * MAX_WIDTH;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } blur_px_t;

  // Register copies and frame position of the predictor.
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [3:0]  window_reg;
  int          in_row, in_col, out_row, out_col;
  bit          in_done;
  logic [31:0] pix_mem [STORE_DEPTH];
  blur_px_t    blurred_q[$];

  assign pending = blurred_q.size();

  function automatic int clamp(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic int mem_addr(input int row, input int col, input int m);
    return ((row % (m + 1)) * MAX_WIDTH + col) % STORE_DEPTH;
  endfunction

  function automatic void restart_frame();
    in_row  = 0;
    in_col  = 0;
    out_row = 0;
    out_col = 0;
    in_done = 0;
  endfunction

  // Advances the frame by one beat; returns 1 when a blurred pixel is due.
  function automatic bit blur_step(input logic act, input logic [31:0] word,
                                   output blur_px_t px);
    int  w, h, m, back, fwd, lag, sr, sg, sb, rr, cc, pos, cnt, area;
    logic [31:0] cur;
    w    = clamp(int'(width_reg), MAX_WIDTH);
    h    = clamp(int'(height_reg), HEIGHT_LIMIT);
    m    = clamp(int'(window_reg), MAX_WINDOW);
    back = m / 2;
    fwd  = m - 1 - back;
    lag  = fwd * w + ((fwd < w - 1) ? fwd : w - 1);
    sr   = 0;
    sg   = 0;
    sb   = 0;
    px   = '0;
    if (!in_done) begin
      // A flush before the frame is complete does nothing.
      if (act) return 0;
      pix_mem[mem_addr(in_row, in_col, m)] = word;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_done = 1;
      end
    end
    pos = out_row * w + out_col;
    cnt = in_row * w + in_col;
    if (!in_done && cnt <= pos + lag) return 0;
    // Window sum; positions off the frame add nothing.
    for (int i = 0; i < m; i++) begin
      rr = out_row - back + i;
      if (rr < 0 || rr >= h) continue;
      for (int j = 0; j < m; j++) begin
        cc = out_col - back + j;
        if (cc < 0 || cc >= w) continue;
        cur = pix_mem[mem_addr(rr, cc, m)];
        sr += cur[7:0];
        sg += cur[15:8];
        sb += cur[23:16];
      end
    end
    area     = m * m;
    cur      = pix_mem[mem_addr(out_row, out_col, m)];
    px.red   = 8'(sr / area);
    px.green = 8'(sg / area);
    px.blue  = 8'(sb / area);
    px.alpha = cur[31:24];
    px.last  = (out_row == h - 1) && (out_col == w - 1);
    if (px.last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  // Track register writes and input beats; compare output beats.
  always @(posedge clk) begin
    blur_px_t px, want;
    if (rst) begin
      width_reg  = 11'd1024;
      height_reg = 13'd1024;
      window_reg = 4'd3;
      restart_frame();
      blurred_q.delete();
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (blurred_q.size() == 0) begin
          report("unexpected beat", 1, 0);
        end else begin
          want = blurred_q.pop_front();
          if (pix_out.red_out !== want.red) report("red_out", pix_out.red_out, want.red);
          if (pix_out.green_out !== want.green)
            report("green_out", pix_out.green_out, want.green);
          if (pix_out.blue_out !== want.blue) report("blue_out", pix_out.blue_out, want.blue);
          if (pix_out.alpha_out !== want.alpha)
            report("alpha_out", pix_out.alpha_out, want.alpha);
          if (pix_out.frame_last !== want.last)
            report("frame_last", pix_out.frame_last, want.last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data[10:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[12:0];
          CFG_WINDOW_SIZE:  window_reg = cfg_data[3:0];
          default: ;
        endcase
        if (cfg_index inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_WINDOW_SIZE})
          restart_frame();
      end
      if (pix_in.valid && pix_in.ready) begin
        if (blur_step(pix_in.action, {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in,
                                      pix_in.red_in}, px))
          blurred_q.push_back(px);
      end
    end
  end
endmodule
`default_nettype wire

/* dv/tb_rgb_box_blur_top.sv */
// Testbench top for the RGB box blur: stimulus, handshake pacing and the verdict.
`default_nettype none
module tb_rgb_box_blur_top;
  import rbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;

  rbb_pix_in_if  pix_in_ch ();
  rbb_pix_out_if pix_out_ch ();

  rgb_box_blur_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_in_ch),
    .pix_out  (pix_out_ch)
  );

  rbb_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_in_ch),
    .pix_out  (pix_out_ch),
    .errors   (errors),
    .pending  (pending)
  );

  // Pacing state; steady is shared by the stimulus and the receiver.
  bit steady;
  bit frame_seen;
  int frame_outs;
  int sent_items;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The receiver stalls at random outside the steady stretch.
  always @(posedge clk) begin
    if (rst) pix_out_ch.ready <= 1'b0;
    else pix_out_ch.ready <= steady || ($urandom_range(99) >= 12);
  end

  // Steps the clock; notes output beats so the drain knows when the frame is done.
  task automatic tick();
    @(posedge clk);
    if (pix_out_ch.valid && pix_out_ch.ready) begin
      frame_outs++;
      if (pix_out_ch.frame_last) frame_seen = 1;
    end
  endtask

  task automatic send_beat(input logic act, input logic [31:0] word);
    while (!steady && $urandom_range(99) < 12) begin
      pix_in_ch.valid <= 1'b0;
      tick();
    end
    pix_in_ch.valid    <= 1'b1;
    pix_in_ch.action   <= act;
    pix_in_ch.red_in   <= word[7:0];
    pix_in_ch.green_in <= word[15:8];
    pix_in_ch.blue_in  <= word[23:16];
    pix_in_ch.alpha_in <= word[31:24];
    do tick(); while (!(pix_in_ch.valid && pix_in_ch.ready));
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    tick();
    cfg_we <= 1'b0;
  endtask

  // Writes the registers, streams one frame and flushes it out.
  task automatic run_frame(input int wr, input int hr, input int mr, input int fill);
    int w, h, total;
    logic [31:0] word;
    w = (wr < 1) ? 1 : ((wr > 1024) ? 1024 : wr);
    h = (hr < 1) ? 1 : ((hr > HEIGHT_LIMIT) ? HEIGHT_LIMIT : hr);
    total = w * h;
    write_reg(CFG_IMAGE_WIDTH, wr);
    write_reg(CFG_IMAGE_HEIGHT, hr);
    write_reg(CFG_WINDOW_SIZE, mr);
    tick();
    frame_seen = 0;
    frame_outs = 0;
    for (int k = 0; k < total; k++) begin
      // Early flush ticks are ignored by the block.
      if ($urandom_range(99) < 5) send_beat(1'b1, $urandom());
      case (fill)
        1:       word = '1;
        2:       word = '0;
        3:       word = k[0] ? '1 : '0;
        default: word = $urandom();
      endcase
      send_beat(1'b0, word);
      sent_items++;
    end
    // Drain; a pixel sent after the frame end is dropped like a flush tick.
    while (!frame_seen)
      send_beat((total - frame_outs >= 2 && $urandom_range(99) < 10) ? 1'b0 : 1'b1,
                $urandom());
    pix_in_ch.valid <= 1'b0;
    while (pending != 0) tick();
    repeat (40) tick();
  endtask

  // Stimulus: directed corner frames, then random frames.
  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_IMAGE_WIDTH;
    cfg_data            = '0;
    pix_in_ch.valid     = 1'b0;
    pix_in_ch.action    = 1'b0;
    pix_in_ch.red_in    = '0;
    pix_in_ch.green_in  = '0;
    pix_in_ch.blue_in   = '0;
    pix_in_ch.alpha_in  = '0;
    steady              = 0;
    sent_items          = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    tick();

    run_frame(1, 1, 1, 1);
    run_frame(0, 0, 0, 0);          // all registers below range clamp to one
    run_frame(5, 4, 4, 1);          // even window, lopsided reach
    run_frame(3, 2, 15, 3);         // window larger than the frame
    run_frame(6, 5, 14, 2);
    run_frame(2047, 1, 2, 0);       // width clamps to the maximum

    while (sent_items < 1550) begin
      steady = (sent_items > 1200 && sent_items < 1380);
      if ($urandom_range(9) == 0)
        run_frame($urandom_range(96), $urandom_range(3), $urandom_range(15),
                  $urandom_range(3));
      else
        run_frame($urandom_range(24), $urandom_range(12), $urandom_range(15),
                  ($urandom_range(9) == 0) ? $urandom_range(3) : 0);
    end
    steady = 0;

    while (pending != 0) tick();
    repeat (300) tick();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
src/rbb_pkg.sv
src/rbb_if.sv
src/rbb_ctrl.sv
src/rbb_datapath.sv
src/rgb_box_blur_top.sv
dv/rbb_checker.sv
dv/tb_rgb_box_blur_top.sv
